### hw/rtl/bqetd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqetd_pkg
// Shared types and constants for the biquad envelope threshold detector.
// ----------------------------------------------------------------------------
package bqetd_pkg;

  localparam int MaxAvg    = 16;
  localparam int IdxW      = $clog2(MaxAvg);
  localparam int LenW      = 5;
  localparam int WinLog    = 10;            // WINDOW = 1024
  localparam int YFrac     = 8;
  localparam int YW        = 12 + YFrac;
  localparam int AccW      = 42;
  localparam int PartW     = 22;
  localparam int CoefW     = 16;
  localparam int SumW      = 14;
  localparam int MeanW     = 21;
  localparam int CntW      = WinLog + 1;

  localparam logic [2:0] REG_B0     = 3'd0;
  localparam logic [2:0] REG_B1     = 3'd1;
  localparam logic [2:0] REG_A1     = 3'd2;
  localparam logic [2:0] REG_A2     = 3'd3;
  localparam logic [2:0] REG_DECAY  = 3'd4;
  localparam logic [2:0] REG_OFFSET = 3'd5;
  localparam logic [2:0] REG_AVGLEN = 3'd6;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_POST,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/bqetd_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqetd_filter
// Direct-form-I biquad, coefficient bits consumed one per cycle.
// ----------------------------------------------------------------------------
module bqetd_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [9:0]            sample,
  input  bqetd_pkg::coef_t      coef,
  output logic                  done,
  output logic [9:0]            filtered
);
  import bqetd_pkg::*;

  logic signed [10:0]   x1, x2, xs;
  logic signed [YW-1:0] y1, y2;
  logic signed [10:0]   xin;
  logic signed [AccW-1:0] acc;
  logic [3:0]           bit_cnt;
  logic                 busy;

  logic signed [PartW-1:0] part;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  acc_next;
  logic signed [AccW-16:0] rnd;
  logic signed [YW-1:0]    y0;
  logic signed [11:0]      yint;
  logic signed [12:0]      yrec;

  always_comb begin
    part = '0;
    if (coef.b0[bit_cnt]) part = part + (PartW'(xs) <<< YFrac);
    if (coef.b1[bit_cnt]) part = part + (PartW'(x1) <<< YFrac);
    if (coef.a1[bit_cnt]) part = part + PartW'(y1);
    if (coef.a2[bit_cnt]) part = part - PartW'(y2);
    term = AccW'(part) <<< bit_cnt;
    // sign bit of a Q1.15 coefficient carries negative weight
    acc_next = (bit_cnt == 4'd15) ? acc - term : acc + term;
    rnd = (AccW-15)'((acc_next + AccW'(1 <<< 14)) >>> 15);
    if (rnd > (AccW-15)'((1 <<< (YW-1)) - 1)) begin
      y0 = {1'b0, {(YW-1){1'b1}}};
    end else if (rnd < -(AccW-15)'(1 <<< (YW-1))) begin
      y0 = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y0 = rnd[YW-1:0];
    end
    yint = 12'(y0 >>> YFrac);
    yrec = 13'(yint) + 13'sd512;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bit_cnt <= '0;
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        bit_cnt <= '0;
        acc <= '0;
        xin <= $signed({1'b0, sample}) - 11'sd512;
        xs <= ($signed({1'b0, sample}) - 11'sd512) + x2;
      end else if (busy) begin
        acc <= acc_next;
        bit_cnt <= bit_cnt + 4'd1;
        if (bit_cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
          y2 <= y1;
          y1 <= y0;
          x2 <= x1;
          x1 <= xin;
          if (yrec < 0) filtered <= '0;
          else if (yrec > 13'sd1023) filtered <= 10'd1023;
          else filtered <= yrec[9:0];
        end
      end
    end
  end

endmodule

### hw/rtl/biquad_envelope_threshold_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_envelope_threshold_detector_core
// Biquad low-pass, peak envelope, moving average and adaptive threshold.
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_*      in   tdata[9:0] sample
// m_*      out  tdata: filtered, envelope, average, above, threshold
// cfg_*    in   index 0..6 register write, data in low bits
//
// A sample passes the bit-serial filter MAC, a sum over the len (1..16)
// entries of the envelope store, and a serial divide by len.
// One item is in flight; the next is taken once the result is loaded.
// A stalled output holds the next result in DONE. Reset is synchronous.
// ----------------------------------------------------------------------------
module biquad_envelope_threshold_detector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  // [9:0] filtered, [19:10] envelope, [29:20] average, [30] above,
  // [41:31] threshold, [47:42] zero
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bqetd_pkg::*;

  coef_t       coef;
  logic [9:0]  decay_step, threshold_offset;
  logic [4:0]  avg_len;

  state_t      state, state_next;
  logic        f_done;
  logic [9:0]  filtered;
  logic [9:0]  peak_env;
  logic [9:0]  avg_store [MaxAvg];
  logic [IdxW-1:0] avg_index;
  logic [LenW-1:0] len, len_eff;
  logic [LenW-1:0] cnt;
  logic [SumW-1:0] sum;
  logic [5:0]  rem;
  logic [9:0]  quo;
  logic [MeanW-1:0] mean_sum;
  logic [CntW-1:0] window_count;
  logic [10:0] threshold_reg;
  logic [IdxW-1:0] wr_idx;
  logic [5:0]  rem_shift;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= 16'sd4762;
      coef.b1 <= 16'sd9524;
      coef.a1 <= 16'sd21988;
      coef.a2 <= 16'sd8268;
      decay_step <= 10'd10;
      threshold_offset <= 10'd20;
      avg_len <= 5'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0:     coef.b0 <= cfg_data;
        REG_B1:     coef.b1 <= cfg_data;
        REG_A1:     coef.a1 <= cfg_data;
        REG_A2:     coef.a2 <= cfg_data;
        REG_DECAY:  decay_step <= cfg_data[9:0];
        REG_OFFSET: threshold_offset <= cfg_data[9:0];
        REG_AVGLEN: avg_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  bqetd_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid && s_tready),
    .sample   (s_tdata[9:0]),
    .coef     (coef),
    .done     (f_done),
    .filtered (filtered)
  );

  always_comb begin
    if (avg_len == '0) len_eff = 5'd1;
    else if (avg_len > 5'(MaxAvg)) len_eff = 5'(MaxAvg);
    else len_eff = avg_len;
    wr_idx = ({1'b0, avg_index} >= len_eff) ? '0 : avg_index;
    rem_shift = {rem[4:0], sum[SumW-1]};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MAC;
      ST_MAC:  if (f_done) state_next = ST_POST;
      ST_POST: state_next = ST_SUM;
      ST_SUM:  if (cnt == len - 5'd1) state_next = ST_DIV;
      ST_DIV:  if (cnt == 5'(SumW - 1)) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      peak_env <= '0;
      avg_index <= '0;
      mean_sum <= '0;
      window_count <= '0;
      threshold_reg <= '0;
      m_tvalid <= 1'b0;
      cnt <= '0;
      for (int i = 0; i < MaxAvg; i++) avg_store[i] <= '0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_POST: begin
          logic [9:0] env;
          env = (filtered > peak_env) ? filtered :
                (peak_env >= decay_step) ? peak_env - decay_step : filtered;
          peak_env <= env;
          avg_store[wr_idx] <= env;
          avg_index <= ({1'b0, wr_idx} + 5'd1 >= len_eff) ? '0 : wr_idx + 1'b1;
          len <= len_eff;
          cnt <= '0;
          sum <= '0;
        end
        ST_SUM: begin
          sum <= sum + SumW'(avg_store[cnt[IdxW-1:0]]);
          cnt <= (cnt == len - 5'd1) ? '0 : cnt + 5'd1;
          rem <= '0;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          sum <= sum << 1;
          if (rem_shift >= {1'b0, len}) begin
            rem <= rem_shift - {1'b0, len};
            quo <= {quo[8:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[8:0], 1'b0};
          end
          cnt <= (cnt == 5'(SumW - 1)) ? '0 : cnt + 5'd1;
        end
        ST_DONE: begin
          // output free or draining this cycle: load and keep tvalid high
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0, threshold_reg, quo > 10'(threshold_reg) &&
                        threshold_reg[10] == 1'b0, quo, peak_env, filtered};
            if (window_count == CntW'((1 << WinLog) - 1)) begin
              threshold_reg <= 11'(((mean_sum + MeanW'(quo)) >> WinLog)
                               + MeanW'(threshold_offset));
              mean_sum <= '0;
              window_count <= '0;
            end else begin
              mean_sum <= mean_sum + MeanW'(quo);
              window_count <= window_count + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_mac: assert property (@(posedge clk) disable iff (rst)
    f_done |-> state == ST_MAC) else $error("filter done outside MAC");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_MAC) else $error("accept did not start MAC");
  a_load_in_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE) else $error("result loaded early");
`endif

endmodule
